### rtl/lmsd_pkg.sv
// lmsd_pkg: shared types, codes and defaults of the led matrix scan driver
// no dependencies; used by every module of the block but lmsd_ram
`timescale 1ns / 1ps

package lmsd_pkg;

    // default sizes handed to the top level parameters
    localparam int SCAN_COLUMNS_DEF = 16;
    localparam int FRAME_WORDS_DEF  = 32;

    // depth of the command queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    // width of one frame store word and the last row index of a scan
    localparam int WORD_W = 16;
    localparam logic [2:0] ROW_LAST = 3'd7;

    // input opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // result kinds
    localparam logic KIND_SHIFT  = 1'b0;
    localparam logic KIND_ENABLE = 1'b1;

    // command classes produced by the front end
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_ENABLE,
        CMD_SCAN
    } cmd_kind_t;

    // one queued command
    typedef struct packed {
        cmd_kind_t   kind;
        logic [4:0]  x;
        logic [3:0]  y;
        logic        value;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [3:0]  lane_bits;
        logic [3:0]  column_select;
        logic        output_enable;
        logic        short_pulse;
        logic        last;
    } res_t;

endpackage

### rtl/lmsd_ram.sv
// lmsd_ram: generic ram, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module lmsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### rtl/lmsd_front.sv
// lmsd_front: accepts input items and classifies them into commands
// depends on lmsd_pkg
`timescale 1ns / 1ps

module lmsd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            opcode,
    input  logic [4:0]      pixel_x,
    input  logic [3:0]      pixel_y,
    input  logic            pixel_value,
    input  logic            q_full,
    output logic            push,
    output lmsd_pkg::cmd_t  cmd
);

    logic phase_reg;
    logic phase_next;

    // accept whenever the queue has room
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // classify: pixel write, or a tick on the enable or the scan phase
    always_comb
    begin
        cmd.x     = pixel_x;
        cmd.y     = pixel_y;
        cmd.value = pixel_value;
        if (opcode == lmsd_pkg::OP_WRITE)
        begin
            cmd.kind = lmsd_pkg::CMD_WRITE;
        end
        else if (phase_reg)
        begin
            cmd.kind = lmsd_pkg::CMD_SCAN;
        end
        else
        begin
            cmd.kind = lmsd_pkg::CMD_ENABLE;
        end
    end

    // phase flips on every accepted tick
    always_comb
    begin
        phase_next = phase_reg;
        if (push && opcode == lmsd_pkg::OP_TICK)
        begin
            phase_next = !phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

### rtl/lmsd_queue.sv
// lmsd_queue: short command queue between front and back end
// depends on lmsd_pkg
`timescale 1ns / 1ps

module lmsd_queue #(
    parameter int DEPTH = lmsd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lmsd_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output lmsd_pkg::cmd_t  head,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lmsd_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // fill count stays in range and moves by at most one
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop) |=> count_reg == $past(count_reg))
        else $error("queue took an item while full");

endmodule

### rtl/lmsd_back.sv
// lmsd_back: carries out queued commands on the frame store, drives results
// depends on lmsd_pkg and lmsd_ram
`timescale 1ns / 1ps

module lmsd_back #(
    parameter int SCAN_COLUMNS = lmsd_pkg::SCAN_COLUMNS_DEF,
    parameter int FRAME_WORDS  = lmsd_pkg::FRAME_WORDS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  lmsd_pkg::cmd_t  q_head,
    output logic            pop,
    input  logic            full_brightness,
    output logic            out_valid,
    input  logic            out_stall,
    output lmsd_pkg::res_t  res
);

    localparam int COL_W  = $clog2(SCAN_COLUMNS);
    localparam int ADDR_W = $clog2(FRAME_WORDS);
    localparam int CX_W   = COL_W + 5;
    localparam int WRAP_W = (ADDR_W + 1 > 5) ? ADDR_W + 1 : 5;
    localparam int WORD_W = lmsd_pkg::WORD_W;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WR_RD,
        B_WR_UPD,
        B_RD01,
        B_RD23,
        B_PUT,
        B_ENA
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    lmsd_pkg::cmd_t    cmd_reg;
    lmsd_pkg::cmd_t    cmd_next;
    logic [COL_W-1:0]  column_reg;
    logic [COL_W-1:0]  column_next;
    logic [2:0]        row_reg;
    logic [2:0]        row_next;
    logic [1:0]        lanes01_reg;
    logic [1:0]        lanes01_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    lmsd_pkg::res_t    res_reg;
    lmsd_pkg::res_t    res_next;
    logic              valid_reg [FRAME_WORDS];
    logic              valid_next [FRAME_WORDS];
    logic              vld_a_reg;
    logic              vld_a_next;
    logic              vld_b_reg;
    logic              vld_b_next;

    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] rd_data_a;
    logic [WORD_W-1:0] rd_data_b;
    logic [WORD_W-1:0] old_word;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;
    logic              out_free;
    logic [CX_W-1:0]   col_ext;
    logic [CX_W-1:0]   sel_full;
    logic              col_hi;
    logic              col_none;
    logic [3:0]        bit_idx;
    logic              bit_a;
    logic              bit_b;
    logic [3:0]        lanes;

    // word index of a frame store address, wrapped into a small store
    function automatic logic [ADDR_W-1:0] wrap_word(input logic [4:0] raw);
        logic [WRAP_W-1:0] v;
        v = WRAP_W'(raw);
        for (int i = 0; i < 8; i++)
        begin
            if (v >= WRAP_W'(FRAME_WORDS))
            begin
                v = v - WRAP_W'(FRAME_WORDS);
            end
        end
        return ADDR_W'(v);
    endfunction

    // column decode: upper half reads lanes 0 and 1 only, from 32 up all dark
    assign col_ext  = CX_W'(column_reg);
    assign col_hi   = (col_ext >= CX_W'(16));
    assign col_none = (col_ext >= CX_W'(32));
    assign bit_idx  = col_ext[3:0];
    assign sel_full = CX_W'(SCAN_COLUMNS - 1) - col_ext;

    // read addresses: write target, first pass, second pass
    assign wr_addr = wrap_word({cmd_reg.x[4], cmd_reg.y});
    always_comb
    begin
        case (state_reg)
            B_WR_RD, B_WR_UPD:
            begin
                addr_a = wr_addr;
                addr_b = wr_addr;
            end
            B_RD01:
            begin
                addr_a = col_hi ? wrap_word({2'b10, row_reg}) : wrap_word({2'b00, row_reg});
                addr_b = col_hi ? wrap_word({2'b11, row_reg}) : wrap_word({2'b01, row_reg});
            end
            default:
            begin
                addr_a = wrap_word({2'b10, row_reg});
                addr_b = wrap_word({2'b11, row_reg});
            end
        endcase
    end

    // read data, words never written read as dark
    assign bit_a    = vld_a_reg && rd_data_a[bit_idx];
    assign bit_b    = vld_b_reg && rd_data_b[bit_idx];
    assign lanes    = col_none ? 4'd0
                    : {(col_hi ? 1'b0 : bit_b), (col_hi ? 1'b0 : bit_a), lanes01_reg};

    // pixel merge for a write
    assign old_word = vld_a_reg ? rd_data_a : '0;
    assign mask     = WORD_W'(1) << cmd_reg.x[3:0];
    assign wr_data  = cmd_reg.value ? (old_word | mask) : (old_word & ~mask);
    assign wr_en    = (state_reg == B_WR_UPD);

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == B_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    lmsd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAME_WORDS)
    ) u_frame (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (addr_b),
        .rd_data_b (rd_data_b)
    );

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        column_next    = column_reg;
        row_next       = row_reg;
        lanes01_next   = lanes01_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        vld_a_next     = valid_reg[addr_a];
        vld_b_next     = valid_reg[addr_b];
        valid_next     = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next = q_head;
                    row_next = lmsd_pkg::ROW_LAST;
                    case (q_head.kind)
                        lmsd_pkg::CMD_WRITE:  state_next = B_WR_RD;
                        lmsd_pkg::CMD_SCAN:   state_next = B_RD01;
                        default:              state_next = B_ENA;
                    endcase
                end
            end
            B_WR_RD:
            begin
                state_next = B_WR_UPD;
            end
            B_WR_UPD:
            begin
                state_next = B_IDLE;
            end
            B_RD01:
            begin
                state_next = B_RD23;
            end
            B_RD23:
            begin
                lanes01_next = {bit_b, bit_a};
                state_next   = B_PUT;
            end
            B_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    res_next.kind          = lmsd_pkg::KIND_SHIFT;
                    res_next.lane_bits     = lanes;
                    res_next.column_select = sel_full[3:0];
                    res_next.output_enable = 1'b0;
                    res_next.short_pulse   = 1'b0;
                    res_next.last          = (row_reg == 3'd0);
                    if (row_reg == 3'd0)
                    begin
                        column_next = (column_reg == COL_W'(SCAN_COLUMNS - 1))
                                    ? '0 : column_reg + 1'b1;
                        state_next  = B_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg - 1'b1;
                        state_next = B_RD01;
                    end
                end
            end
            B_ENA:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    res_next.kind          = lmsd_pkg::KIND_ENABLE;
                    res_next.lane_bits     = 4'd0;
                    res_next.column_select = 4'd0;
                    res_next.output_enable = 1'b1;
                    res_next.short_pulse   = !full_brightness;
                    res_next.last          = 1'b1;
                    state_next             = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // state, store valid bits and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cmd_reg       <= '0;
            column_reg    <= '0;
            row_reg       <= '0;
            lanes01_reg   <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            vld_a_reg     <= 1'b0;
            vld_b_reg     <= 1'b0;
            for (int i = 0; i < FRAME_WORDS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            lanes01_reg   <= lanes01_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
            vld_a_reg     <= vld_a_next;
            vld_b_reg     <= vld_b_next;
            valid_reg     <= valid_next;
        end
    end

    // a popped command always starts work
    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg != B_IDLE)
        else $error("command popped but sequencer stayed idle");

    // the column moves on exactly when the latch strobe item is loaded
    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PUT && out_free && row_reg == 3'd0)
        |=> column_reg != $past(column_reg))
        else $error("column did not advance after latch strobe");

    // a scan never leaves the output register mid-row with a stale strobe
    a_strobe_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PUT && out_free && row_reg != 3'd0)
        |=> !res_reg.last && state_reg == B_RD01)
        else $error("latch strobe on a row other than row zero");

endmodule

### rtl/led_matrix_scan_driver_core.sv
// led_matrix_scan_driver_core: top level of the led matrix scan driver
// depends on lmsd_pkg, lmsd_front, lmsd_queue, lmsd_back, lmsd_ram
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   opcode, pixel_x, pixel_y, pixel_value
//  out       output     out_valid / out_stall kind, lane_bits, column_select,
//                                             output_enable, short_pulse, last
//  cfg       input      cfg_valid / cfg_ready cfg_data (full_brightness)
//
// back end states: write idle, read, update; enable tick idle, enable; scan
// tick idle, then read, read, put per row: each row needs two passes over the
// two read ports of the frame store ram. the front end takes an item per cycle
// until the four entry command queue fills. reset clears the store through one
// valid bit per word, so no clearing pass is needed. a stalled output holds
// the back end in place while the front end keeps filling the queue.
`timescale 1ns / 1ps

module led_matrix_scan_driver_core #(
    parameter int SCAN_COLUMNS = lmsd_pkg::SCAN_COLUMNS_DEF,
    parameter int FRAME_WORDS  = lmsd_pkg::FRAME_WORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [4:0] pixel_x,
    input  logic [3:0] pixel_y,
    input  logic       pixel_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [3:0] lane_bits,
    output logic [3:0] column_select,
    output logic       output_enable,
    output logic       short_pulse,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic            brightness_reg;
    logic            brightness_next;
    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    lmsd_pkg::cmd_t  push_cmd;
    lmsd_pkg::cmd_t  q_head;
    lmsd_pkg::res_t  res;

    // brightness register, always ready
    assign cfg_ready = 1'b1;
    always_comb
    begin
        brightness_next = brightness_reg;
        if (cfg_valid && cfg_ready)
        begin
            brightness_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 1'b1;
        end
        else
        begin
            brightness_reg <= brightness_next;
        end
    end

    // front end: accept and classify
    lmsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_value (pixel_value),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    // command queue
    lmsd_queue #(
        .DEPTH (lmsd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // back end: frame store and result sequencer
    lmsd_back #(
        .SCAN_COLUMNS (SCAN_COLUMNS),
        .FRAME_WORDS  (FRAME_WORDS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .pop             (pop),
        .full_brightness (brightness_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .res             (res)
    );

    // result fields
    assign kind          = res.kind;
    assign lane_bits     = res.lane_bits;
    assign column_select = res.column_select;
    assign output_enable = res.output_enable;
    assign short_pulse   = res.short_pulse;
    assign last          = res.last;

endmodule

### bench/tb_led_matrix_scan_driver_core.sv
// tb_led_matrix_scan_driver_core: self-checking bench for the led matrix scan driver
// drives pixel writes and refresh ticks, predicts enable and shift results from a shadow frame
// depends on lmsd_pkg and led_matrix_scan_driver_core
`timescale 1ns / 1ps

module tb_led_matrix_scan_driver_core;

    localparam int SCAN_COLS    = lmsd_pkg::SCAN_COLUMNS_DEF;
    localparam int STORE_WORDS  = lmsd_pkg::FRAME_WORDS_DEF;
    // writes leave no result, so let the command queue empty before a register write
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;

    // one input item
    typedef struct packed {
        logic       opcode;
        logic [4:0] x;
        logic [3:0] y;
        logic       value;
    } pixel_cmd_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic       opcode        = 1'b0;
    logic [4:0] pixel_x       = '0;
    logic [3:0] pixel_y       = '0;
    logic       pixel_value   = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic       kind;
    logic [3:0] lane_bits;
    logic [3:0] column_select;
    logic       output_enable;
    logic       short_pulse;
    logic       last;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic       cfg_data      = 1'b0;

    // shadow copy of the block state
    logic [lmsd_pkg::WORD_W-1:0] frame_shadow [STORE_WORDS];
    logic [3:0]        col_shadow    = '0;
    logic              phase_shadow  = 1'b0;
    logic              bright_shadow = 1'b1;

    pixel_cmd_t      cmd_pending [$];
    lmsd_pkg::res_t  results_due [$];
    pixel_cmd_t cmd_now     = '0;
    int         send_gap    = 0;
    int         recv_gap    = 0;
    int         errors      = 0;
    int         quiet_cycles = 0;
    logic       calm        = 1'b0;

    led_matrix_scan_driver_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .lane_bits     (lane_bits),
        .column_select (column_select),
        .output_enable (output_enable),
        .short_pulse   (short_pulse),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // pixel lookup in the shadow frame, upper half of x in the second bank
    function automatic logic pixel_at(int x, int y);
        int w;
        w = (y + (x > 15 ? 16 : 0)) % STORE_WORDS;
        return frame_shadow[w][x % 16];
    endfunction

    // apply one accepted item to the shadow state and queue its results
    task automatic frame_apply(input pixel_cmd_t c);
        lmsd_pkg::res_t r;
        int   row;
        int   w;
        int   col;
        col = col_shadow;
        if (c.opcode == lmsd_pkg::OP_WRITE)
        begin
            w = (int'(c.y) + (c.x > 5'd15 ? 16 : 0)) % STORE_WORDS;
            frame_shadow[w][c.x[3:0]] = c.value;
        end
        else if (!phase_shadow)
        begin
            // enable phase: one result, drivers on
            phase_shadow    = 1'b1;
            r               = '0;
            r.kind          = lmsd_pkg::KIND_ENABLE;
            r.output_enable = 1'b1;
            r.short_pulse   = !bright_shadow;
            r.last          = 1'b1;
            results_due.push_back(r);
        end
        else
        begin
            // scan phase: rows 7 down to 0 of the current column
            phase_shadow = 1'b0;
            for (row = int'(lmsd_pkg::ROW_LAST); row >= 0; row--)
            begin
                r               = '0;
                r.kind          = lmsd_pkg::KIND_SHIFT;
                r.lane_bits     = {pixel_at(col + 16, row + 8), pixel_at(col + 16, row),
                                   pixel_at(col, row + 8), pixel_at(col, row)};
                r.column_select = 4'(SCAN_COLS - 1 - col);
                r.last          = (row == 0);
                results_due.push_back(r);
            end
            col_shadow = (col == SCAN_COLS - 1) ? 4'd0 : 4'(col + 1);
        end
    endtask

    function automatic pixel_cmd_t make_cmd(logic op, int x, int y, logic v);
        pixel_cmd_t c;
        c.opcode = op;
        c.x      = 5'(x);
        c.y      = 4'(y);
        c.value  = v;
        return c;
    endfunction

    // random item, tick density rising with the phase
    function automatic pixel_cmd_t rand_cmd(int bias);
        pixel_cmd_t c;
        c.opcode = ($urandom_range(0, 99) < 35 + 5 * bias)
                 ? lmsd_pkg::OP_TICK : lmsd_pkg::OP_WRITE;
        c.x      = 5'($urandom_range(0, 31));
        c.y      = 4'($urandom_range(0, 15));
        c.value  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // sender holds off until every queued item is in and every result is out
    task automatic wait_quiet();
        @(negedge clk);
        while (cmd_pending.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic brightness_write(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bright_shadow = v;
        cfg_valid     <= 1'b0;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        pixel_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                frame_apply(cmd_now);
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cmd_pending.size() != 0)
                begin
                    nxt         = cmd_pending.pop_front();
                    cmd_now     <= nxt;
                    opcode      <= nxt.opcode;
                    pixel_x     <= nxt.x;
                    pixel_y     <= nxt.y;
                    pixel_value <= nxt.value;
                    in_valid    <= 1'b1;
                    send_gap    <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        lmsd_pkg::res_t want;
        int   g;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result item with none expected: kind %0d lane_bits %h last %0d",
                           kind, lane_bits, last);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        errors++;
                    end
                    if (lane_bits !== want.lane_bits)
                    begin
                        $error("lane_bits: expected %h, got %h", want.lane_bits, lane_bits);
                        errors++;
                    end
                    if (column_select !== want.column_select)
                    begin
                        $error("column_select: expected %0d, got %0d",
                               want.column_select, column_select);
                        errors++;
                    end
                    if (output_enable !== want.output_enable)
                    begin
                        $error("output_enable: expected %0d, got %0d",
                               want.output_enable, output_enable);
                        errors++;
                    end
                    if (short_pulse !== want.short_pulse)
                    begin
                        $error("short_pulse: expected %0d, got %0d",
                               want.short_pulse, short_pulse);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors++;
                    end
                end
            end
            if (recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                g         = pick_gap();
                out_stall <= (g != 0);
                recv_gap  <= (g == 0) ? 0 : g - 1;
            end
        end
    end

    // watchdog on cycles where no channel moves
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin : stim_proc
        int i;
        int p;
        int n;
        for (i = 0; i < STORE_WORDS; i++)
            frame_shadow[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corner pixels, set and clear, ticks with junk fields
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 0, 0, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 31, 15, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 16, 0, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 0, 15, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 16, 8, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 15, 7, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 31, 0, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 0, 8, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 0, 8, 1'b0));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 1, 7, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 17, 15, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_TICK, 31, 15, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_TICK, 0, 0, 1'b0));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_TICK, 21, 10, 1'b0));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_TICK, 10, 5, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 16, 0, 1'b0));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_WRITE, 2, 3, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_TICK, 0, 0, 1'b0));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_TICK, 0, 0, 1'b0));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_TICK, 31, 15, 1'b1));
        cmd_pending.push_back(make_cmd(lmsd_pkg::OP_TICK, 31, 15, 1'b1));
        wait_quiet();

        // random phases, brightness toggled between them
        for (p = 0; p < 6; p++)
        begin
            brightness_write(p[0]);
            calm = (p == 3);
            for (n = 0; n < 60; n++)
                cmd_pending.push_back(rand_cmd(p));
            wait_quiet();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
